### hdl/x86_ild_pkg.sv
package x86_ild_pkg;

  // longest instruction the decoder will report
  localparam int unsigned MAX_LENGTH = 15;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_PREFIX = 3'd1,
    PH_ESC    = 3'd2,
    PH_MODRM  = 3'd3,
    PH_SIB    = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    C_ONE    = 4'd0,
    C_IMM8   = 4'd1,
    C_IMMV   = 4'd2,
    C_MOFFS  = 4'd3,
    C_FAR    = 4'd4,
    C_IMM16  = 4'd5,
    C_ENTER  = 4'd6,
    C_RM     = 4'd7,
    C_RM_I8  = 4'd8,
    C_RM_IV  = 4'd9,
    C_GRP3_8 = 4'd10,
    C_GRP3_V = 4'd11
  } insn_class_t;

  // conditional test immediate of group 3
  typedef enum logic [1:0] {
    TK_NONE = 2'd0,
    TK_IMM8 = 2'd1,
    TK_IMMV = 2'd2
  } test_kind_t;

  localparam logic [7:0] OP_OPSIZE = 8'h66;
  localparam logic [7:0] OP_ADSIZE = 8'h67;
  localparam logic [7:0] OP_ESCAPE = 8'h0F;

  function automatic logic is_prefix(input logic [7:0] b);
    logic r;
    r = 1'b0;
    case (b) inside
      8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65, 8'hF0, 8'hF2, 8'hF3: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic insn_class_t classify(input logic [7:0] op);
    insn_class_t c;
    c = C_ONE;
    if (op < 8'h40) begin
      // alu block: rm forms, then al,imm8 / ax,immv, then one-byte push/pop/daa
      unique case (op[2:0]) inside
        3'd0, 3'd1, 3'd2, 3'd3: c = C_RM;
        3'd4:                   c = C_IMM8;
        3'd5:                   c = C_IMMV;
        default:                c = C_ONE;
      endcase
    end else begin
      unique case (op) inside
        8'h6A, [8'h70:8'h7F], 8'hA8, [8'hB0:8'hB7], 8'hCD, 8'hD4, 8'hD5,
        [8'hE0:8'hE7], 8'hEB:                              c = C_IMM8;
        8'h68, 8'hA9, [8'hB8:8'hBF], 8'hE8, 8'hE9:          c = C_IMMV;
        [8'hA0:8'hA3]:                                     c = C_MOFFS;
        8'hEA, 8'h9A:                                      c = C_FAR;
        8'hC2, 8'hCA:                                      c = C_IMM16;
        8'hC8:                                             c = C_ENTER;
        8'h62, 8'h63, [8'h84:8'h8F], 8'hC4, 8'hC5, [8'hD0:8'hD3],
        [8'hD8:8'hDF], 8'hFE, 8'hFF:                        c = C_RM;
        8'h6B, 8'h80, 8'h83, 8'hC0, 8'hC1, 8'hC6:           c = C_RM_I8;
        8'h69, 8'h81, 8'hC7:                               c = C_RM_IV;
        8'hF6:                                             c = C_GRP3_8;
        8'hF7:                                             c = C_GRP3_V;
        default:                                           c = C_ONE;
      endcase
    end
    return c;
  endfunction

endpackage

### hdl/x86_real_mode_insn_length.sv
// channel  dir  tdata                          tuser
// s_*      in   [7:0] code_byte                [0] first
// m_*      out  [3:0] length, [7:4] zero       [0] capped
//
// one code byte is taken every cycle unless a stalled result holds the input
// register; a byte waits in the input register, is decoded against the running
// state and, if it settles the length, lands in the result register once the result side has room
// rst is synchronous: decode goes idle with sizes cleared, both registers empty
// a stalled result holds the input register; bytes keep flowing into it
// while a result waits only until that register is full
module x86_real_mode_insn_length (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] code_byte
  input  logic       s_tuser,   // [0] first
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [3:0] length, [7:4] zero
  output logic       m_tuser    // [0] capped
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_first;

  // decode state
  x86_ild_pkg::phase_t     phase, phase_next;
  logic [3:0]              byte_count, byte_count_next;
  logic                    operand_size_32, operand_size_32_next;
  logic                    address_size_32, address_size_32_next;
  logic [2:0]              pending_immediate, pending_immediate_next;
  x86_ild_pkg::test_kind_t test_immediate_kind, test_immediate_kind_next;
  logic [1:0]              saved_mod, saved_mod_next;

  // result register
  logic [3:0] out_length;
  logic       out_capped;

  logic       in_go;
  logic       emit;
  logic [4:0] total;
  logic       cap;

  // the byte in the input register is decoded once the result side has room
  assign in_go    = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || in_go;

  always_comb begin
    x86_ild_pkg::phase_t     ph;
    logic [3:0]              bc;
    logic                    o32;
    logic                    a32;
    logic [2:0]              pend;
    x86_ild_pkg::test_kind_t kind;
    logic [1:0]              smod;
    logic [3:0]              cnt;
    logic [2:0]              immv;
    logic [3:0]              extra;
    logic [2:0]              disp;
    logic [1:0]              mod_f;
    logic [2:0]              reg_f;
    logic [2:0]              rm_f;
    ph   = phase;
    bc   = byte_count;
    o32  = operand_size_32;
    a32  = address_size_32;
    pend = pending_immediate;
    kind = test_immediate_kind;
    smod = saved_mod;
    cnt   = 4'd0;
    immv  = 3'd2;
    extra = 4'd0;
    disp  = 3'd0;
    mod_f = in_byte[7:6];
    reg_f = in_byte[5:3];
    rm_f  = in_byte[2:0];
    emit  = 1'b0;
    total = 5'd0;

    // start flag drops any decode in progress
    if (in_first) begin
      ph   = x86_ild_pkg::PH_PREFIX;
      bc   = 4'd0;
      o32  = 1'b0;
      a32  = 1'b0;
      pend = 3'd0;
      kind = x86_ild_pkg::TK_NONE;
      smod = 2'd0;
    end

    if (ph != x86_ild_pkg::PH_IDLE) begin
      cnt  = bc + 4'd1;
      bc   = cnt;
      immv = o32 ? 3'd4 : 3'd2;
      unique case (ph)
        x86_ild_pkg::PH_PREFIX: begin
          if (x86_ild_pkg::is_prefix(in_byte)) begin
            // stays in prefix phase
          end else if (in_byte == x86_ild_pkg::OP_OPSIZE) begin
            o32 = ~o32;
          end else if (in_byte == x86_ild_pkg::OP_ADSIZE) begin
            a32 = ~a32;
          end else if (in_byte == x86_ild_pkg::OP_ESCAPE) begin
            ph = x86_ild_pkg::PH_ESC;
          end else begin
            case (x86_ild_pkg::classify(in_byte))
              x86_ild_pkg::C_IMM8: begin
                emit = 1'b1; total = 5'(cnt) + 5'd1;
              end
              x86_ild_pkg::C_IMMV: begin
                emit = 1'b1; total = 5'(cnt) + 5'(immv);
              end
              x86_ild_pkg::C_MOFFS: begin
                emit = 1'b1; total = 5'(cnt) + (a32 ? 5'd4 : 5'd2);
              end
              x86_ild_pkg::C_FAR: begin
                emit = 1'b1; total = 5'(cnt) + (o32 ? 5'd6 : 5'd4);
              end
              x86_ild_pkg::C_IMM16: begin
                emit = 1'b1; total = 5'(cnt) + 5'd2;
              end
              x86_ild_pkg::C_ENTER: begin
                emit = 1'b1; total = 5'(cnt) + 5'd3;
              end
              x86_ild_pkg::C_RM: begin
                pend = 3'd0; kind = x86_ild_pkg::TK_NONE; ph = x86_ild_pkg::PH_MODRM;
              end
              x86_ild_pkg::C_RM_I8: begin
                pend = 3'd1; kind = x86_ild_pkg::TK_NONE; ph = x86_ild_pkg::PH_MODRM;
              end
              x86_ild_pkg::C_RM_IV: begin
                pend = immv; kind = x86_ild_pkg::TK_NONE; ph = x86_ild_pkg::PH_MODRM;
              end
              x86_ild_pkg::C_GRP3_8: begin
                pend = 3'd0; kind = x86_ild_pkg::TK_IMM8; ph = x86_ild_pkg::PH_MODRM;
              end
              x86_ild_pkg::C_GRP3_V: begin
                pend = 3'd0; kind = x86_ild_pkg::TK_IMMV; ph = x86_ild_pkg::PH_MODRM;
              end
              default: begin
                // one-byte and unknown opcodes
                emit = 1'b1; total = 5'(cnt);
              end
            endcase
          end
        end
        x86_ild_pkg::PH_ESC: begin
          if (in_byte[7:4] == 4'h8) begin
            // near jcc with full displacement
            emit = 1'b1; total = 5'(cnt) + 5'(immv);
          end else begin
            // shld/shrd by immediate carry imm8
            pend = (in_byte == 8'hA4 || in_byte == 8'hAC) ? 3'd1 : 3'd0;
            kind = x86_ild_pkg::TK_NONE;
            ph   = x86_ild_pkg::PH_MODRM;
          end
        end
        x86_ild_pkg::PH_MODRM: begin
          extra = 4'(pend);
          if (kind != x86_ild_pkg::TK_NONE && reg_f <= 3'd1)
            extra = extra + ((kind == x86_ild_pkg::TK_IMM8) ? 4'd1 : 4'(immv));
          pend = extra[2:0];
          if (mod_f == 2'd3) begin
            emit = 1'b1; total = 5'(cnt) + 5'(extra);
          end else if (!a32) begin
            if (mod_f == 2'd0 && rm_f == 3'd6) disp = 3'd2;
            else if (mod_f == 2'd1)            disp = 3'd1;
            else if (mod_f == 2'd2)            disp = 3'd2;
            emit = 1'b1; total = 5'(cnt) + 5'(extra) + 5'(disp);
          end else if (rm_f == 3'd4) begin
            smod = mod_f;
            ph   = x86_ild_pkg::PH_SIB;
          end else begin
            if (mod_f == 2'd0 && rm_f == 3'd5) disp = 3'd4;
            else if (mod_f == 2'd1)            disp = 3'd1;
            else if (mod_f == 2'd2)            disp = 3'd4;
            emit = 1'b1; total = 5'(cnt) + 5'(extra) + 5'(disp);
          end
        end
        x86_ild_pkg::PH_SIB: begin
          // base of five with mod zero means a 32-bit displacement
          if (smod == 2'd0 && rm_f == 3'd5) disp = 3'd4;
          else if (smod == 2'd1)            disp = 3'd1;
          else if (smod == 2'd2)            disp = 3'd4;
          emit = 1'b1; total = 5'(cnt) + 5'(pend) + 5'(disp);
        end
        default: begin
          ph = x86_ild_pkg::PH_IDLE;
        end
      endcase

      // unfinished decode that has run out of bytes
      if (!emit && ph != x86_ild_pkg::PH_IDLE &&
          5'(cnt) >= 5'(x86_ild_pkg::MAX_LENGTH)) begin
        emit  = 1'b1;
        total = 5'(cnt);
      end
      if (emit) ph = x86_ild_pkg::PH_IDLE;
    end

    cap = total >= 5'(x86_ild_pkg::MAX_LENGTH);

    phase_next               = ph;
    byte_count_next          = bc;
    operand_size_32_next     = o32;
    address_size_32_next     = a32;
    pending_immediate_next   = pend;
    test_immediate_kind_next = kind;
    saved_mod_next           = smod;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (in_go) begin
      in_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_first <= s_tuser;
    end
  end

  // decode state, updated once per decoded byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= x86_ild_pkg::PH_IDLE;
      byte_count          <= 4'd0;
      operand_size_32     <= 1'b0;
      address_size_32     <= 1'b0;
      pending_immediate   <= 3'd0;
      test_immediate_kind <= x86_ild_pkg::TK_NONE;
      saved_mod           <= 2'd0;
    end else if (in_go) begin
      phase               <= phase_next;
      byte_count          <= byte_count_next;
      operand_size_32     <= operand_size_32_next;
      address_size_32     <= address_size_32_next;
      pending_immediate   <= pending_immediate_next;
      test_immediate_kind <= test_immediate_kind_next;
      saved_mod           <= saved_mod_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_go && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (in_go && emit) begin
      out_length <= cap ? 4'(x86_ild_pkg::MAX_LENGTH) : total[3:0];
      out_capped <= cap;
    end
  end

  assign m_tdata = {4'd0, out_length};
  assign m_tuser = out_capped;

endmodule

### tb/sv/insn_length_checker.sv
`timescale 1ns / 100ps

module insn_length_checker
  import x86_ild_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] code_byte
  input  logic       s_tuser,   // [0] first
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [3:0] length, [7:4] zero
  input  logic       m_tuser,   // [0] capped
  output int         lengths_owed,
  output int         error_count
);

  typedef struct packed {
    logic [3:0] length;
    logic       capped;
  } length_result_t;

  length_result_t length_q[$];
  int             mismatches = 0;

  // opcode tables of the decoder's own making
  insn_class_t op_class [256];
  bit          plain_prefix [256];

  // decode state
  phase_t      ph;
  logic [3:0]  count;
  logic        opsize32;
  logic        adsize32;
  logic [2:0]  pend_imm;
  test_kind_t  tkind;
  logic [1:0]  saved_mod;

  initial begin
    int i;
    for (i = 0; i < 256; i++) begin
      op_class[i]     = C_ONE;
      plain_prefix[i] = 1'b0;
      if (i < 'h40) begin
        if (i % 8 < 4)       op_class[i] = C_RM;
        else if (i % 8 == 4) op_class[i] = C_IMM8;
        else if (i % 8 == 5) op_class[i] = C_IMMV;
      end
    end
    plain_prefix['h26] = 1'b1; plain_prefix['h2E] = 1'b1; plain_prefix['h36] = 1'b1;
    plain_prefix['h3E] = 1'b1; plain_prefix['h64] = 1'b1; plain_prefix['h65] = 1'b1;
    plain_prefix['hF0] = 1'b1; plain_prefix['hF2] = 1'b1; plain_prefix['hF3] = 1'b1;

    for (i = 'h70; i <= 'h7F; i++) op_class[i] = C_IMM8;
    for (i = 'hB0; i <= 'hB7; i++) op_class[i] = C_IMM8;
    for (i = 'hE0; i <= 'hE7; i++) op_class[i] = C_IMM8;
    op_class['h6A] = C_IMM8; op_class['hA8] = C_IMM8; op_class['hCD] = C_IMM8;
    op_class['hD4] = C_IMM8; op_class['hD5] = C_IMM8; op_class['hEB] = C_IMM8;

    for (i = 'hB8; i <= 'hBF; i++) op_class[i] = C_IMMV;
    op_class['h68] = C_IMMV; op_class['hA9] = C_IMMV;
    op_class['hE8] = C_IMMV; op_class['hE9] = C_IMMV;

    for (i = 'hA0; i <= 'hA3; i++) op_class[i] = C_MOFFS;
    op_class['hEA] = C_FAR;   op_class['h9A] = C_FAR;
    op_class['hC2] = C_IMM16; op_class['hCA] = C_IMM16;
    op_class['hC8] = C_ENTER;

    for (i = 'h84; i <= 'h8F; i++) op_class[i] = C_RM;
    for (i = 'hD0; i <= 'hD3; i++) op_class[i] = C_RM;
    for (i = 'hD8; i <= 'hDF; i++) op_class[i] = C_RM;
    op_class['h62] = C_RM; op_class['h63] = C_RM; op_class['hC4] = C_RM;
    op_class['hC5] = C_RM; op_class['hFE] = C_RM; op_class['hFF] = C_RM;

    op_class['h6B] = C_RM_I8; op_class['h80] = C_RM_I8; op_class['h83] = C_RM_I8;
    op_class['hC0] = C_RM_I8; op_class['hC1] = C_RM_I8; op_class['hC6] = C_RM_I8;
    op_class['h69] = C_RM_IV; op_class['h81] = C_RM_IV; op_class['hC7] = C_RM_IV;
    op_class['hF6] = C_GRP3_8;
    op_class['hF7] = C_GRP3_V;
  end

  task automatic clear_decode();
    ph        = PH_IDLE;
    count     = '0;
    opsize32  = 1'b0;
    adsize32  = 1'b0;
    pend_imm  = '0;
    tkind     = TK_NONE;
    saved_mod = '0;
  endtask

  task automatic enter_modrm(input int imm, input test_kind_t kind);
    pend_imm = imm[2:0];
    tkind    = kind;
    ph       = PH_MODRM;
  endtask

  task automatic book_length(input int total);
    length_result_t r;
    r.capped = (total >= MAX_LENGTH);
    r.length = r.capped ? 4'(MAX_LENGTH) : 4'(total);
    length_q.push_back(r);
    ph = PH_IDLE;
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  // advance the decode by one accepted code byte
  task automatic decode_code_byte(input logic [7:0] b, input logic first_flag);
    logic [3:0] cnt;
    logic [1:0] mod_f;
    logic [2:0] reg_f;
    logic [2:0] rm_f;
    int         immv;
    int         extra;
    int         total;
    bit         done;
    done  = 1'b0;
    total = 0;
    if (first_flag) begin
      clear_decode();
      ph = PH_PREFIX;
    end
    if (ph == PH_IDLE) return;
    count = count + 4'd1;
    cnt   = count;
    immv  = opsize32 ? 4 : 2;
    case (ph)
      PH_PREFIX: begin
        if (plain_prefix[b]) begin
          // segment, lock and rep prefixes only add a byte
        end else if (b == OP_OPSIZE) begin
          opsize32 = ~opsize32;
        end else if (b == OP_ADSIZE) begin
          adsize32 = ~adsize32;
        end else if (b == OP_ESCAPE) begin
          ph = PH_ESC;
        end else begin
          done = 1'b1;
          case (op_class[b])
            C_IMM8:   total = cnt + 1;
            C_IMMV:   total = cnt + immv;
            C_MOFFS:  total = cnt + (adsize32 ? 4 : 2);
            C_FAR:    total = cnt + (opsize32 ? 6 : 4);
            C_IMM16:  total = cnt + 2;
            C_ENTER:  total = cnt + 3;
            C_RM:     begin done = 1'b0; enter_modrm(0, TK_NONE); end
            C_RM_I8:  begin done = 1'b0; enter_modrm(1, TK_NONE); end
            C_RM_IV:  begin done = 1'b0; enter_modrm(immv, TK_NONE); end
            C_GRP3_8: begin done = 1'b0; enter_modrm(0, TK_IMM8); end
            C_GRP3_V: begin done = 1'b0; enter_modrm(0, TK_IMMV); end
            default:  total = cnt;
          endcase
        end
      end
      PH_ESC: begin
        // near conditional jumps carry a full-size displacement
        if (b[7:4] == 4'h8) begin
          done  = 1'b1;
          total = cnt + immv;
        end else begin
          enter_modrm((b == 8'hA4 || b == 8'hAC) ? 1 : 0, TK_NONE);
        end
      end
      PH_MODRM: begin
        mod_f = b[7:6];
        reg_f = b[5:3];
        rm_f  = b[2:0];
        extra = pend_imm;
        if (tkind != TK_NONE && reg_f <= 3'd1) extra += (tkind == TK_IMM8) ? 1 : immv;
        pend_imm = extra[2:0];
        if (mod_f == 2'd3) begin
          done  = 1'b1;
          total = cnt + extra;
        end else if (!adsize32) begin
          if (mod_f == 2'd0 && rm_f == 3'd6) extra += 2;
          else if (mod_f == 2'd1)            extra += 1;
          else if (mod_f == 2'd2)            extra += 2;
          done  = 1'b1;
          total = cnt + extra;
        end else if (rm_f == 3'd4) begin
          saved_mod = mod_f;
          ph        = PH_SIB;
        end else begin
          if (mod_f == 2'd0 && rm_f == 3'd5) extra += 4;
          else if (mod_f == 2'd1)            extra += 1;
          else if (mod_f == 2'd2)            extra += 4;
          done  = 1'b1;
          total = cnt + extra;
        end
      end
      PH_SIB: begin
        // base 5 with no displacement byte means a disp32 instead
        extra = pend_imm;
        if (saved_mod == 2'd0 && b[2:0] == 3'd5) extra += 4;
        else if (saved_mod == 2'd1)             extra += 1;
        else if (saved_mod == 2'd2)             extra += 4;
        done  = 1'b1;
        total = cnt + extra;
      end
      default: begin
        ph = PH_IDLE;
        return;
      end
    endcase
    if (done) book_length(total);
    else if (cnt >= MAX_LENGTH) book_length(cnt);
  endtask

  always @(posedge clk) begin : watch
    length_result_t want;
    if (rst) begin
      clear_decode();
      length_q.delete();
    end else begin
      // a result can never stem from a byte taken on the same edge
      if (m_tvalid && m_tready) begin
        if (length_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result: len %0d capped %0b data %h",
                                  m_tdata[3:0], m_tuser, m_tdata));
        end else begin
          want = length_q.pop_front();
          if (m_tdata[3:0] != want.length || m_tuser !== want.capped ||
              m_tdata[7:4] != 4'd0)
            note_mismatch($sformatf(
              "result mismatch: expected len %0d capped %0b, got len %0d capped %0b pad %h",
              want.length, want.capped, m_tdata[3:0], m_tuser, m_tdata[7:4]));
        end
      end
      if (s_tvalid && s_tready) decode_code_byte(s_tdata, s_tuser);
    end
    lengths_owed <= length_q.size();
    error_count  <= mismatches;
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // total run length before giving up, generous against the slowest legal run
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;
  // long receiver hold-off so that both pipeline registers fill and s_tready drops
  localparam int unsigned HOLD_CYCLES  = 300;
  // code bytes of the random part, ignored trailing bytes included
  localparam int unsigned RANDOM_BYTES = 1320;

  // prefixes, the two size toggles included
  localparam logic [7:0] PREFIX_POOL [0:10] = '{
    8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65, 8'hF0, 8'hF2, 8'hF3, 8'h66, 8'h67
  };
  // opcodes with the richer length rules, picked more often than chance would
  localparam logic [7:0] HOT_OPS [0:19] = '{
    8'hF6, 8'hF7, 8'h69, 8'h81, 8'hC7, 8'h6B, 8'h80, 8'h83, 8'hC0, 8'hC6,
    8'h8B, 8'hEA, 8'h9A, 8'hA1, 8'hA2, 8'hC8, 8'hC2, 8'hCA, 8'hE8, 8'h0F
  };

  // shapes of the receiver's ready pattern
  typedef enum logic [1:0] {
    RDY_FREE   = 2'd0,
    RDY_COIN   = 2'd1,
    RDY_MOSTLY = 2'd2,
    RDY_SPARSE = 2'd3
  } ready_mode_t;

  logic       clk;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;   // [7:0] code_byte
  logic       s_tuser  = 1'b0;    // [0] first
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;            // [3:0] length, [7:4] zero
  logic       m_tuser;            // [0] capped

  int lengths_owed;
  int error_count;
  int burst_left   = 0;
  bit hold_pending = 1'b0;

  logic [7:0] insn_bytes[$];

  x86_real_mode_insn_length u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  insn_length_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .lengths_owed (lengths_owed),
    .error_count  (error_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // offer one code byte and hold it until the transfer happens
  // the sender runs in bursts; a gap may open before each new burst
  task automatic send_byte(input logic [7:0] b, input logic first_flag);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= first_flag;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  // stop offering until every predicted length has been delivered
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (lengths_owed != 0) @(posedge clk);
  endtask

  // receiver: segments of differing ready density, plus one long hold-off on request
  initial begin : receiver
    int          seg;
    ready_mode_t mode;
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        seg  = $urandom_range(4, 40);
        mode = ready_mode_t'($urandom_range(0, 3));
        repeat (seg) begin
          case (mode)
            RDY_FREE:   m_tready <= 1'b1;
            RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RDY_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
            default:    m_tready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int  i;
    int  n_pref;
    int  pick;
    int  keep;
    int  useful;
    bit  paused;
    useful = 0;
    paused = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    // a byte with no decode running is dropped
    send_byte(8'h90, 1'b0);
    // undefined opcode counts as one byte
    send_byte(8'h82, 1'b1);
    // lowest and highest byte values: add r/m8 with a register modrm
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    // escape abandoned by a new start, then mov ax,imm16
    send_byte(x86_ild_pkg::OP_ESCAPE, 1'b1);
    send_byte(8'hB8, 1'b1);
    // escaped shift with imm8, register form
    send_byte(x86_ild_pkg::OP_ESCAPE, 1'b1);
    send_byte(8'hA4, 1'b0);
    send_byte(8'hC0, 1'b0);
    // 32-bit addressing test with sib and disp32 base
    send_byte(x86_ild_pkg::OP_ADSIZE, 1'b1);
    send_byte(8'hF7, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h25, 1'b0);
    // far jump with 32-bit operand size
    send_byte(x86_ild_pkg::OP_OPSIZE, 1'b1);
    send_byte(8'hEA, 1'b0);
    // runaway prefix string hits the length cap before the decode ends
    for (i = 0; i < 14; i++) send_byte(PREFIX_POOL[i % 11], (i == 0));
    send_byte(x86_ild_pkg::OP_ESCAPE, 1'b0);

    drain_results();
    hold_pending = 1'b1;

    // random part: mostly well-formed instructions with random content
    while (useful < RANDOM_BYTES) begin
      insn_bytes.delete();
      pick = $urandom_range(0, 19);
      if (pick == 0)     n_pref = $urandom_range(10, 16);
      else if (pick < 8) n_pref = $urandom_range(1, 3);
      else               n_pref = 0;
      repeat (n_pref) insn_bytes.push_back(PREFIX_POOL[$urandom_range(0, 10)]);
      if ($urandom_range(0, 3) == 0) insn_bytes.push_back(x86_ild_pkg::OP_ADSIZE);

      pick = $urandom_range(0, 5);
      if (pick == 0) begin
        insn_bytes.push_back(x86_ild_pkg::OP_ESCAPE);
        if ($urandom_range(0, 2) == 0)
          insn_bytes.push_back(8'h80 | 8'($urandom_range(0, 15)));
        else if ($urandom_range(0, 2) == 0)
          insn_bytes.push_back($urandom_range(0, 1) ? 8'hA4 : 8'hAC);
        else
          insn_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 3) begin
        insn_bytes.push_back(HOT_OPS[$urandom_range(0, 19)]);
      end else begin
        insn_bytes.push_back(8'($urandom_range(0, 255)));
      end
      // modrm, sib and a spare byte; whatever lies past the settled length is dropped
      repeat (3) insn_bytes.push_back(8'($urandom_range(0, 255)));

      // now and then cut the instruction short so the next start breaks in
      if ($urandom_range(0, 9) == 0) begin
        keep = $urandom_range(1, insn_bytes.size() - 1);
        while (insn_bytes.size() > keep) void'(insn_bytes.pop_back());
      end

      for (i = 0; i < insn_bytes.size(); i++) send_byte(insn_bytes[i], (i == 0));
      useful += insn_bytes.size();

      if (!paused && useful >= RANDOM_BYTES / 2) begin
        paused = 1'b1;
        drain_results();
      end
    end

    // wind down: everything owed, then an idle wait for stray outputs
    drain_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #RUN_LIMIT_NS;
    $display("TB_ERROR");
    $finish;
  end

endmodule
